// ----- rtl/wsel_pkg.sv -----
// wsel_pkg: shared types and constants for the weight sorted entry list
// no dependencies
`timescale 1ns / 1ps
package wsel_pkg;
    localparam int MAX_ENTRIES = 64;
    localparam int ID_BITS     = 16;
    localparam int WEIGHT_BITS = 12;
    localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_BITS  = 18;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_DETACH = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] entry_id;
        logic [11:0] entry_weight;
    } t_cmd;

    typedef struct packed {
        logic        found;
        logic        rejected;
        logic [11:0] match_weight;
        logic [5:0]  match_position;
        logic [6:0]  entry_count;
        logic [17:0] weight_total;
    } t_result;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [WEIGHT_BITS-1:0] weight;
    } t_entry;
endpackage

// ----- rtl/wsel_ram.sv -----
// wsel_ram: single write, single read entry memory, registered read
// depends on wsel_pkg
`timescale 1ns / 1ps
module wsel_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [wsel_pkg::ADDR_BITS-1:0] i_waddr,
    input  wsel_pkg::t_entry           i_wdata,
    input  logic [wsel_pkg::ADDR_BITS-1:0] i_raddr,
    output wsel_pkg::t_entry           o_rdata
);
    import wsel_pkg::*;
    t_entry r_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/weight_sorted_entry_list_top.sv -----
// weight_sorted_entry_list_top: ordered (id, weight) list kept in one memory
// depends on wsel_pkg and wsel_ram
`timescale 1ns / 1ps
// one command word is taken while busy is low; its result word appears for one
// cycle with o_done high and cannot be held off. the entries sit in a single
// memory with a registered read port, so searches and shifts walk the list an
// entry a cycle. an insert shifts the entries from the match position to the
// rear, and a detach shifts only the entries behind the match, so search and
// shift together cover the list about once. clear, append, rejected inserts and
// unused codes go from idle straight to the done state. no clearing pass is
// needed after reset.
module weight_sorted_entry_list_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  wsel_pkg::t_cmd     i_cmd,
    output logic               o_done,
    output wsel_pkg::t_result  o_result
);
    import wsel_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHUP   = 3'd2; // move entries towards rear, walking backwards
    localparam logic [2:0] S_SHDN   = 3'd3; // move entries towards front
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]            r_state;
    t_cmd                  r_cmd;
    logic [COUNT_BITS-1:0] r_count;
    logic [TOTAL_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_idx;     // search read address; r_idx-1 was issued last cycle
    logic                  r_rvalid;  // read data is valid and belongs to r_idx-1
    logic [ADDR_BITS-1:0]  r_pos;
    logic                  r_found;
    logic                  r_rej;
    logic [WEIGHT_BITS-1:0] r_mw;

    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr;
    t_entry                wdata, rdata;

    wsel_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [COUNT_BITS-1:0] rd_idx;
    logic                  hit;
    always_comb begin
        rd_idx = r_idx - COUNT_BITS'(1);
        hit = 1'b0;
        if (r_cmd.op == OP_INSERT) begin
            // position 0 is heavier-than-front, later ones stop at not-greater
            hit = (rd_idx == '0) ? (r_cmd.entry_weight > rdata.weight)
                                 : (rdata.weight <= r_cmd.entry_weight);
        end else begin
            hit = (rdata.id == r_cmd.entry_id);
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_idx[ADDR_BITS-1:0];
        wdata = rdata;
        raddr = r_idx[ADDR_BITS-1:0];
        case (r_state)
            S_IDLE: begin
                // front entry is read as a word is taken
                raddr = '0;
            end
            S_SHUP: begin
                // first cycle reads idx-1, then one ahead of the pending write
                raddr = r_idx[ADDR_BITS-1:0] - (r_rvalid ? ADDR_BITS'(2) : ADDR_BITS'(1));
                if (r_rvalid) begin
                    we = 1'b1;
                    waddr = r_idx[ADDR_BITS-1:0];
                end
            end
            S_SHDN: begin
                raddr = r_idx[ADDR_BITS-1:0];
                if (r_rvalid) begin
                    we = 1'b1;
                    waddr = rd_idx[ADDR_BITS-1:0] - ADDR_BITS'(1);
                end
            end
            S_DONE: begin
                if (r_cmd.op == OP_INSERT || r_cmd.op == OP_APPEND) begin
                    we = !r_rej;
                    waddr = r_pos;
                    wdata = '{id: r_cmd.entry_id, weight: r_cmd.entry_weight};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_rvalid <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rvalid <= 1'b0;
                    if (start) begin
                        r_cmd <= i_cmd;
                        r_found <= 1'b0;
                        r_rej <= 1'b0;
                        r_mw <= '0;
                        r_pos <= '0;
                        r_idx <= '0;
                        r_state <= S_DONE;
                        case (i_cmd.op)
                            OP_INSERT, OP_APPEND: begin
                                if (r_count == COUNT_BITS'(MAX_ENTRIES)) begin
                                    r_rej <= 1'b1;
                                end else if (i_cmd.op == OP_APPEND || r_count == '0) begin
                                    r_pos <= r_count[ADDR_BITS-1:0];
                                end else begin
                                    r_idx <= COUNT_BITS'(1);
                                    r_rvalid <= 1'b1;
                                    r_state <= S_SEARCH;
                                end
                            end
                            OP_FIND, OP_DETACH: begin
                                if (r_count != '0) begin
                                    r_idx <= COUNT_BITS'(1);
                                    r_rvalid <= 1'b1;
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEARCH: begin
                    r_idx <= r_idx + COUNT_BITS'(1);
                    if (hit || r_idx == r_count) begin
                        r_pos <= hit ? rd_idx[ADDR_BITS-1:0] : r_count[ADDR_BITS-1:0];
                        r_rvalid <= 1'b0;
                        r_state <= S_DONE;
                        if (r_cmd.op == OP_INSERT) begin
                            // shift [pos, count) up by one, from the rear
                            if (hit) begin
                                r_idx <= r_count;
                                r_state <= S_SHUP;
                            end
                        end else if (hit) begin
                            r_found <= 1'b1;
                            r_mw <= rdata.weight;
                            if (r_cmd.op == OP_DETACH) begin
                                // read of pos+1 is already on its way
                                r_idx <= r_idx + COUNT_BITS'(1);
                                r_rvalid <= 1'b1;
                                r_state <= S_SHDN;
                            end
                        end
                    end
                end
                S_SHUP: begin
                    // r_idx: destination; first cycle issues read of idx-1
                    if (r_rvalid) begin
                        if (r_idx[ADDR_BITS-1:0] == r_pos + ADDR_BITS'(1)) begin
                            r_rvalid <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx - COUNT_BITS'(1);
                        end
                    end else begin
                        r_rvalid <= 1'b1;
                    end
                end
                S_SHDN: begin
                    // r_idx-1 is the address read last cycle, destination one below
                    if (rd_idx >= r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_rvalid <= 1'b1;
                        r_idx <= r_idx + COUNT_BITS'(1);
                    end
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_cmd.op)
                        OP_INSERT, OP_APPEND: begin
                            if (!r_rej) begin
                                r_count <= r_count + COUNT_BITS'(1);
                                r_total <= r_total + TOTAL_BITS'(r_cmd.entry_weight);
                            end
                        end
                        OP_DETACH: begin
                            if (r_found) begin
                                r_count <= r_count - COUNT_BITS'(1);
                                r_total <= r_total - TOTAL_BITS'(r_mw);
                            end
                        end
                        OP_CLEAR: begin
                            r_count <= '0;
                            r_total <= '0;
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // shdn bookkeeping: r_idx starts at pos+2 with a read of pos+1 pending
    // (set raddr from r_idx in S_SHDN), rd_idx is the word now on rdata

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_result.found = r_found;
        o_result.rejected = r_rej;
        o_result.match_weight = r_mw;
        o_result.match_position = r_rej ? 6'd0 : (r_found || r_cmd.op == OP_INSERT ||
            r_cmd.op == OP_APPEND) ? r_pos : 6'd0;
        o_result.entry_count = r_count;
        o_result.weight_total = r_total;
    end
endmodule

// ----- rtl/wsel_checker.sv -----
// wsel_checker: port-level checks on the weight sorted entry list
// depends on wsel_pkg; bound to weight_sorted_entry_list_top
`timescale 1ns / 1ps
module wsel_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input wsel_pkg::t_result  o_result
);
    import wsel_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while busy");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.entry_count <= 7'(MAX_ENTRIES)) else $error("count beyond capacity");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.found && o_result.rejected)) else $error("found and rejected");
endmodule

bind weight_sorted_entry_list_top wsel_checker u_wsel_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_result(o_result)
);
